>>> hw/rtl/i2cms_pkg.sv
// package for the i2c master bit sequencer: command codes, phase codes,
// register indexes and reset values; no dependencies
package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;

   typedef enum logic [2:0] {
      CMD_IDLE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_WRITE    = 3'd3,
      CMD_READ     = 3'd4,
      CMD_WAIT_ACK = 3'd5
   } cmd_type;

   typedef logic [3:0] phase_type;

   // phase codes, shared entry phase
   localparam phase_type PH_INIT      = 4'd0;
   // start / stop
   localparam phase_type PH_SS_EDGE   = 4'd1;
   // write byte
   localparam phase_type PH_WR_DATA   = 4'd1;
   localparam phase_type PH_WR_HIGH   = 4'd2;
   localparam phase_type PH_WR_LOW    = 4'd3;
   // read byte
   localparam phase_type PH_RD_RISE   = 4'd1;
   localparam phase_type PH_RD_SAMPLE = 4'd2;
   localparam phase_type PH_RD_FALL   = 4'd3;
   localparam phase_type PH_RD_NEXT   = 4'd4;
   localparam phase_type PH_RD_ACK    = 4'd5;
   // wait ack
   localparam phase_type PH_WA_POLL   = 4'd1;
   localparam phase_type PH_WA_HOLD   = 4'd2;
   localparam phase_type PH_WA_STOP   = 4'd3;

   localparam logic [7:0] ACK_PULSE_TICKS = 8'd2;

   // csr register indexes (word address)
   localparam logic [2:0] REG_ACK_TIMEOUT_POLLS = 3'd0;
   localparam logic [2:0] REG_WRITE_HALF_PERIOD = 3'd1;
   localparam logic [2:0] REG_READ_HALF_PERIOD  = 3'd2;
   localparam logic [2:0] REG_START_STOP_HOLD   = 3'd3;
   localparam logic [2:0] REG_ACK_POLL_INTERVAL = 3'd4;
   localparam logic [2:0] REG_POST_ACK_HOLD     = 3'd5;

   localparam logic [7:0] RST_ACK_TIMEOUT_POLLS = 8'd250;
   localparam logic [7:0] RST_WRITE_HALF_PERIOD = 8'd2;
   localparam logic [7:0] RST_READ_HALF_PERIOD  = 8'd20;
   localparam logic [7:0] RST_START_STOP_HOLD   = 8'd4;
   localparam logic [7:0] RST_ACK_POLL_INTERVAL = 8'd2;
   localparam logic [7:0] RST_POST_ACK_HOLD     = 8'd20;

endpackage

>>> hw/rtl/i2c_master_bit_sequencer.sv
// i2c master bit sequencer top level: tick stream in, line state stream out
// depends on i2cms_pkg
// the response to an accepted request is captured in the output register
// throughput: one request per cycle while each response is taken; each request is one tick and the whole
//   line step of that tick (including zero-hold chains) settles in one registered pass
// the output register frees itself when the response is taken, so a new request
//   is accepted in the same cycle as the previous response leaves
// reset: synchronous active high; sequencer idle, scl/sda high and driven, registers at defaults
module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tx_byte, [8] ack_after_read, [9] sda_in, rest zero
   input  logic [2:0]  req_tuser,   // [2:0] func
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] scl, [1] sda_level, [2] sda_drive, [3] busy_res,
                                    // [4] done_res, [12:5] rx_byte, [13] ack_failed, rest zero
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // request fields
   logic [2:0] req_func;
   logic [7:0] req_tx_byte;
   logic       req_ack_after_read;
   logic       req_sda_in;
   logic       req_accept;

   assign req_func           = req_tuser[2:0];
   assign req_tx_byte        = req_tdata[7:0];
   assign req_ack_after_read = req_tdata[8];
   assign req_sda_in         = req_tdata[9];

   // configuration registers
   logic [7:0] ack_timeout_polls_ff;
   logic [7:0] write_half_period_ff;
   logic [7:0] read_half_period_ff;
   logic [7:0] start_stop_hold_ff;
   logic [7:0] ack_poll_interval_ff;
   logic [7:0] post_ack_hold_ff;
   logic       csr_write;
   logic [2:0] csr_index;

   // sequencer state
   cmd_type    cmd_ff, cmd_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] hold_ff, hold_in;
   logic [7:0] poll_ff, poll_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       dir_ff, dir_in;
   logic [7:0] rx_byte_ff, rx_byte_in;
   logic       fail_ff, fail_in;
   logic       ack_level_ff, ack_level_in;
   logic       done_in;
   logic       first_sda;
   logic [3:0] rd_left;

   // output register
   logic        rsp_tvalid_ff;
   logic [15:0] rsp_tdata_ff, rsp_tdata_in;

   // ------------------------------------------------------------------
   // csr port: always ready, writes land on the access cycle
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_polls_ff <= RST_ACK_TIMEOUT_POLLS;
         write_half_period_ff <= RST_WRITE_HALF_PERIOD;
         read_half_period_ff  <= RST_READ_HALF_PERIOD;
         start_stop_hold_ff   <= RST_START_STOP_HOLD;
         ack_poll_interval_ff <= RST_ACK_POLL_INTERVAL;
         post_ack_hold_ff     <= RST_POST_ACK_HOLD;
      end else if (csr_write) begin
         case (csr_index)
            REG_ACK_TIMEOUT_POLLS: ack_timeout_polls_ff <= csr_pwdata[7:0];
            REG_WRITE_HALF_PERIOD: write_half_period_ff <= csr_pwdata[7:0];
            REG_READ_HALF_PERIOD:  read_half_period_ff  <= csr_pwdata[7:0];
            REG_START_STOP_HOLD:   start_stop_hold_ff   <= csr_pwdata[7:0];
            REG_ACK_POLL_INTERVAL: ack_poll_interval_ff <= csr_pwdata[7:0];
            REG_POST_ACK_HOLD:     post_ack_hold_ff     <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ACK_TIMEOUT_POLLS: csr_prdata = {24'd0, ack_timeout_polls_ff};
         REG_WRITE_HALF_PERIOD: csr_prdata = {24'd0, write_half_period_ff};
         REG_READ_HALF_PERIOD:  csr_prdata = {24'd0, read_half_period_ff};
         REG_START_STOP_HOLD:   csr_prdata = {24'd0, start_stop_hold_ff};
         REG_ACK_POLL_INTERVAL: csr_prdata = {24'd0, ack_poll_interval_ff};
         REG_POST_ACK_HOLD:     csr_prdata = {24'd0, post_ack_hold_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // handshake: take a request whenever the output register is empty or draining
   // ------------------------------------------------------------------
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   // ------------------------------------------------------------------
   // next state: one tick of the sequencer
   // a step whose hold is zero runs in the same tick, so the steps of each
   // command are laid out in the order they can chain within a tick; the
   // zero-period write and read loops collapse into closed forms
   // ------------------------------------------------------------------
   always_comb begin
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      hold_in      = hold_ff;
      poll_in      = poll_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      dir_in       = dir_ff;
      rx_byte_in   = rx_byte_ff;
      fail_in      = fail_ff;
      ack_level_in = ack_level_ff;
      done_in      = 1'b0;
      first_sda    = 1'b0;
      rd_left      = 4'd0;

      // count down the hold, or pick up a new command when idle
      if (cmd_ff != CMD_IDLE) begin
         if (hold_ff != 8'd0) begin
            hold_in = hold_ff - 8'd1;
         end
      end else if (req_func >= CMD_START && req_func <= CMD_WAIT_ACK) begin
         cmd_in   = cmd_type'(req_func);
         phase_in = PH_INIT;
         hold_in  = 8'd0;
         if (req_func == CMD_WRITE) begin
            shift_in = req_tx_byte;
         end
         if (req_func == CMD_READ) begin
            ack_level_in = req_ack_after_read;
         end
      end

      case (cmd_in)
         CMD_START, CMD_STOP: begin
            first_sda = (cmd_in == CMD_START);
            if (hold_in == 8'd0 && phase_in == PH_INIT) begin
               dir_in   = 1'b1;
               sda_in   = first_sda;
               scl_in   = 1'b1;
               phase_in = PH_SS_EDGE;
               hold_in  = start_stop_hold_ff;
            end
            if (hold_in == 8'd0 && phase_in == PH_SS_EDGE) begin
               sda_in   = ~first_sda;
               cmd_in   = CMD_IDLE;
               phase_in = PH_INIT;
               done_in  = 1'b1;
            end
         end

         CMD_WRITE: begin
            if (hold_in == 8'd0 && phase_in == PH_INIT) begin
               dir_in       = 1'b1;
               scl_in       = 1'b0;
               bit_index_in = 4'd0;
               phase_in     = PH_WR_DATA;
            end
            if (hold_in == 8'd0 && phase_in == PH_WR_HIGH) begin
               scl_in   = 1'b1;
               phase_in = PH_WR_LOW;
               hold_in  = write_half_period_ff;
            end
            // scl falls at the end of a bit, then the next bit is set up at once
            if (hold_in == 8'd0 && phase_in == PH_WR_LOW) begin
               scl_in       = 1'b0;
               bit_index_in = bit_index_in + 4'd1;
               if (bit_index_in < 4'(BITS_PER_BYTE)) begin
                  phase_in = PH_WR_DATA;
               end else begin
                  cmd_in   = CMD_IDLE;
                  phase_in = PH_INIT;
                  done_in  = 1'b1;
               end
            end
            if (hold_in == 8'd0 && phase_in == PH_WR_DATA) begin
               if (write_half_period_ff == 8'd0) begin
                  // rest of the byte in one tick: last bit out is the original lsb,
                  // which has moved up by the bits already sent
                  sda_in       = shift_in[bit_index_in[2:0]];
                  shift_in     = 8'd0;
                  scl_in       = 1'b0;
                  bit_index_in = 4'(BITS_PER_BYTE);
                  cmd_in       = CMD_IDLE;
                  phase_in     = PH_INIT;
                  done_in      = 1'b1;
               end else begin
                  sda_in   = shift_in[7];
                  shift_in = {shift_in[6:0], 1'b0};
                  phase_in = PH_WR_HIGH;
                  hold_in  = write_half_period_ff;
               end
            end
         end

         CMD_READ: begin
            if (hold_in == 8'd0 && phase_in == PH_INIT) begin
               dir_in       = 1'b0;
               scl_in       = 1'b0;
               shift_in     = 8'd0;
               bit_index_in = 4'd0;
               phase_in     = PH_RD_RISE;
               hold_in      = read_half_period_ff;
            end
            // zero period: the remaining samples all see this tick's sda,
            // then the ack pulse starts
            if (hold_in == 8'd0 && read_half_period_ff == 8'd0 &&
                (phase_in == PH_RD_RISE || phase_in == PH_RD_SAMPLE ||
                 phase_in == PH_RD_FALL || phase_in == PH_RD_NEXT)) begin
               if (phase_in == PH_RD_RISE || phase_in == PH_RD_SAMPLE) begin
                  rd_left = 4'(BITS_PER_BYTE) - bit_index_in;
               end else begin
                  rd_left = 4'(BITS_PER_BYTE - 1) - bit_index_in;
               end
               shift_in     = (shift_in << rd_left) |
                              (req_sda_in ? ~(8'hFF << rd_left) : 8'd0);
               bit_index_in = 4'(BITS_PER_BYTE);
               dir_in       = 1'b1;
               sda_in       = ~ack_level_in;
               scl_in       = 1'b1;
               phase_in     = PH_RD_ACK;
               hold_in      = ACK_PULSE_TICKS;
            end
            if (hold_in == 8'd0 && phase_in == PH_RD_NEXT) begin
               bit_index_in = bit_index_in + 4'd1;
               if (bit_index_in < 4'(BITS_PER_BYTE)) begin
                  phase_in = PH_RD_RISE;
               end else begin
                  dir_in   = 1'b1;
                  sda_in   = ~ack_level_in;
                  scl_in   = 1'b1;
                  phase_in = PH_RD_ACK;
                  hold_in  = ACK_PULSE_TICKS;
               end
            end
            if (hold_in == 8'd0 && phase_in == PH_RD_RISE) begin
               scl_in   = 1'b1;
               phase_in = PH_RD_SAMPLE;
               hold_in  = read_half_period_ff;
            end
            if (hold_in == 8'd0 && phase_in == PH_RD_SAMPLE) begin
               shift_in = {shift_in[6:0], req_sda_in};
               phase_in = PH_RD_FALL;
               hold_in  = read_half_period_ff;
            end
            if (hold_in == 8'd0 && phase_in == PH_RD_FALL) begin
               scl_in   = 1'b0;
               phase_in = PH_RD_NEXT;
               hold_in  = read_half_period_ff;
            end
            if (hold_in == 8'd0 && phase_in == PH_RD_ACK) begin
               scl_in = 1'b0;
               if (ack_level_in) begin
                  sda_in = 1'b1;
               end
               rx_byte_in = shift_in;
               cmd_in     = CMD_IDLE;
               phase_in   = PH_INIT;
               done_in    = 1'b1;
            end
         end

         CMD_WAIT_ACK: begin
            if (hold_in == 8'd0 && phase_in == PH_INIT) begin
               sda_in   = 1'b1;
               dir_in   = 1'b0;
               scl_in   = 1'b1;
               poll_in  = 8'd0;
               phase_in = PH_WA_POLL;
            end
            if (hold_in == 8'd0 && phase_in == PH_WA_POLL) begin
               if (!req_sda_in) begin
                  scl_in   = 1'b0;
                  phase_in = PH_WA_HOLD;
                  hold_in  = post_ack_hold_ff;
               end else if (poll_in >= ack_timeout_polls_ff ||
                            ack_poll_interval_ff == 8'd0) begin
                  // zero interval: polls repeat within the tick up to the limit
                  if (poll_in < ack_timeout_polls_ff) begin
                     poll_in = ack_timeout_polls_ff;
                  end
                  dir_in   = 1'b1;
                  sda_in   = 1'b0;
                  scl_in   = 1'b1;
                  phase_in = PH_WA_STOP;
                  hold_in  = start_stop_hold_ff;
               end else begin
                  poll_in = poll_in + 8'd1;
                  hold_in = ack_poll_interval_ff;
               end
            end
            if (hold_in == 8'd0 && phase_in == PH_WA_HOLD) begin
               fail_in  = 1'b0;
               cmd_in   = CMD_IDLE;
               phase_in = PH_INIT;
               done_in  = 1'b1;
            end
            if (hold_in == 8'd0 && phase_in == PH_WA_STOP) begin
               sda_in   = 1'b1;
               fail_in  = 1'b1;
               cmd_in   = CMD_IDLE;
               phase_in = PH_INIT;
               done_in  = 1'b1;
            end
         end

         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // response packing, highest field first
   // ------------------------------------------------------------------
   always_comb begin
      rsp_tdata_in = {2'b00, fail_in, rx_byte_in, done_in, (cmd_in != CMD_IDLE),
                      dir_in, sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= CMD_IDLE;
         phase_ff      <= PH_INIT;
         bit_index_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         hold_ff       <= 8'd0;
         poll_ff       <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         dir_ff        <= 1'b1;
         rx_byte_ff    <= 8'd0;
         fail_ff       <= 1'b0;
         ack_level_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            cmd_ff       <= cmd_in;
            phase_ff     <= phase_in;
            bit_index_ff <= bit_index_in;
            shift_ff     <= shift_in;
            hold_ff      <= hold_in;
            poll_ff      <= poll_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            dir_ff       <= dir_in;
            rx_byte_ff   <= rx_byte_in;
            fail_ff      <= fail_in;
            ack_level_ff <= ack_level_in;
         end
         if (req_accept) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // an idle sequencer never carries a pending hold
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_IDLE) |-> (hold_ff == 8'd0))
      else $error("idle sequencer with nonzero hold");

   // a completed command is never reported busy in the same response
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_tdata_ff[4] && rsp_tdata_ff[3]))
      else $error("response both done and busy");

   // a plain tick on an idle sequencer leaves it idle
   a_tick_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd_ff == CMD_IDLE && req_func == CMD_IDLE) |=> (cmd_ff == CMD_IDLE))
      else $error("idle tick started a command");

   // bit counter never passes the byte length during a write or read
   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_WRITE || cmd_ff == CMD_READ) |-> (bit_index_ff <= 4'(BITS_PER_BYTE)))
      else $error("bit index out of range");

endmodule

>>> tb/i2cms_checker.sv
`timescale 1ns / 100ps
// line-state checker for the i2c master bit sequencer: tracks register writes,
// predicts one response per request and compares it; depends on i2cms_pkg
module i2cms_checker
   import i2cms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_total,
   output int          pending_total,
   output int          checked_total,
   output int          command_total,
   output int          timeout_total
);

   typedef struct packed {
      logic       scl;
      logic       sda_level;
      logic       sda_drive;
      logic       busy;
      logic       done;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } line_state_type;

   line_state_type line_q[$];
   line_state_type want_line, got_line;

   // register copies
   logic [7:0] cfg_timeout, cfg_wr_half, cfg_rd_half, cfg_ss_hold, cfg_poll_int, cfg_post_ack;

   // sequencer copy
   cmd_type    active_cmd;
   phase_type  seq_phase;
   logic [3:0] bit_cnt;
   logic [7:0] shift_q, hold_cnt, poll_cnt, rx_q;
   logic       scl_lvl, sda_lvl, sda_oe, fail_q, ack_lvl, completed;

   int mismatch_cnt = 0;
   int checked_cnt = 0;
   int command_cnt = 0;
   int timeout_cnt = 0;

   function void clear_sequencer();
      cfg_timeout  = RST_ACK_TIMEOUT_POLLS;
      cfg_wr_half  = RST_WRITE_HALF_PERIOD;
      cfg_rd_half  = RST_READ_HALF_PERIOD;
      cfg_ss_hold  = RST_START_STOP_HOLD;
      cfg_poll_int = RST_ACK_POLL_INTERVAL;
      cfg_post_ack = RST_POST_ACK_HOLD;
      active_cmd = CMD_IDLE;
      seq_phase  = PH_INIT;
      bit_cnt    = '0;
      shift_q    = '0;
      hold_cnt   = '0;
      poll_cnt   = '0;
      rx_q       = '0;
      scl_lvl    = 1'b1;
      sda_lvl    = 1'b1;
      sda_oe     = 1'b1;
      fail_q     = 1'b0;
      ack_lvl    = 1'b0;
      completed  = 1'b0;
   endfunction

   function void goto_phase(phase_type next, logic [7:0] hold);
      seq_phase = next;
      hold_cnt  = hold;
   endfunction

   function void close_command();
      active_cmd = CMD_IDLE;
      seq_phase  = PH_INIT;
      hold_cnt   = '0;
      completed  = 1'b1;
   endfunction

   // start drives sda high first, stop low; the edge follows the hold
   function void start_stop_step(logic first_sda);
      if (seq_phase == PH_INIT) begin
         sda_oe  = 1'b1;
         sda_lvl = first_sda;
         scl_lvl = 1'b1;
         goto_phase(PH_SS_EDGE, cfg_ss_hold);
      end else begin
         sda_lvl = ~first_sda;
         close_command();
      end
   endfunction

   function void write_step();
      case (seq_phase)
         PH_INIT: begin
            sda_oe  = 1'b1;
            scl_lvl = 1'b0;
            bit_cnt = '0;
            goto_phase(PH_WR_DATA, 8'd0);
         end
         PH_WR_DATA: begin
            sda_lvl = shift_q[7];
            shift_q = shift_q << 1;
            goto_phase(PH_WR_HIGH, cfg_wr_half);
         end
         PH_WR_HIGH: begin
            scl_lvl = 1'b1;
            goto_phase(PH_WR_LOW, cfg_wr_half);
         end
         default: begin
            scl_lvl = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) goto_phase(PH_WR_DATA, 8'd0);
            else close_command();
         end
      endcase
   endfunction

   function void read_step(logic sda);
      case (seq_phase)
         PH_INIT: begin
            sda_oe  = 1'b0;
            scl_lvl = 1'b0;
            shift_q = '0;
            bit_cnt = '0;
            goto_phase(PH_RD_RISE, cfg_rd_half);
         end
         PH_RD_RISE: begin
            scl_lvl = 1'b1;
            goto_phase(PH_RD_SAMPLE, cfg_rd_half);
         end
         PH_RD_SAMPLE: begin
            shift_q = {shift_q[6:0], sda};
            goto_phase(PH_RD_FALL, cfg_rd_half);
         end
         PH_RD_FALL: begin
            scl_lvl = 1'b0;
            goto_phase(PH_RD_NEXT, cfg_rd_half);
         end
         PH_RD_NEXT: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) begin
               goto_phase(PH_RD_RISE, 8'd0);
            end else begin
               // ack drives sda low, nack leaves it high
               sda_oe  = 1'b1;
               sda_lvl = ~ack_lvl;
               scl_lvl = 1'b1;
               goto_phase(PH_RD_ACK, ACK_PULSE_TICKS);
            end
         end
         default: begin
            scl_lvl = 1'b0;
            if (ack_lvl) sda_lvl = 1'b1;
            rx_q = shift_q;
            close_command();
         end
      endcase
   endfunction

   function void wait_ack_step(logic sda);
      case (seq_phase)
         PH_INIT: begin
            sda_lvl  = 1'b1;
            sda_oe   = 1'b0;
            scl_lvl  = 1'b1;
            poll_cnt = '0;
            goto_phase(PH_WA_POLL, 8'd0);
         end
         PH_WA_POLL: begin
            if (!sda) begin
               scl_lvl = 1'b0;
               goto_phase(PH_WA_HOLD, cfg_post_ack);
            end else if (poll_cnt >= cfg_timeout) begin
               // give up: run a stop sequence
               sda_oe  = 1'b1;
               sda_lvl = 1'b0;
               scl_lvl = 1'b1;
               goto_phase(PH_WA_STOP, cfg_ss_hold);
            end else begin
               poll_cnt = poll_cnt + 8'd1;
               goto_phase(PH_WA_POLL, cfg_poll_int);
            end
         end
         PH_WA_HOLD: begin
            fail_q = 1'b0;
            close_command();
         end
         default: begin
            sda_lvl = 1'b1;
            fail_q  = 1'b1;
            timeout_cnt++;
            close_command();
         end
      endcase
   endfunction

   // zero holds chain further steps into the same tick
   function void settle_tick(logic sda);
      while (active_cmd != CMD_IDLE && hold_cnt == 8'd0) begin
         case (active_cmd)
            CMD_START:    start_stop_step(1'b1);
            CMD_STOP:     start_stop_step(1'b0);
            CMD_WRITE:    write_step();
            CMD_READ:     read_step(sda);
            CMD_WAIT_ACK: wait_ack_step(sda);
            default:      close_command();
         endcase
      end
   endfunction

   function line_state_type predict_line(logic [2:0] func, logic [7:0] tx, logic ack,
                                         logic sda);
      line_state_type line;
      completed = 1'b0;
      if (active_cmd != CMD_IDLE) begin
         // commands while busy are plain ticks
         if (hold_cnt > 8'd0) hold_cnt = hold_cnt - 8'd1;
         settle_tick(sda);
      end else if (func >= CMD_START && func <= CMD_WAIT_ACK) begin
         active_cmd = cmd_type'(func);
         seq_phase  = PH_INIT;
         hold_cnt   = '0;
         if (active_cmd == CMD_WRITE) shift_q = tx;
         if (active_cmd == CMD_READ) ack_lvl = ack;
         settle_tick(sda);
      end
      line.scl        = scl_lvl;
      line.sda_level  = sda_lvl;
      line.sda_drive  = sda_oe;
      line.busy       = (active_cmd != CMD_IDLE);
      line.done       = completed;
      line.rx_byte    = rx_q;
      line.ack_failed = fail_q;
      return line;
   endfunction

   function void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_sequencer();
         line_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_line.scl        = rsp_tdata[0];
            got_line.sda_level  = rsp_tdata[1];
            got_line.sda_drive  = rsp_tdata[2];
            got_line.busy       = rsp_tdata[3];
            got_line.done       = rsp_tdata[4];
            got_line.rx_byte    = rsp_tdata[12:5];
            got_line.ack_failed = rsp_tdata[13];
            if (line_q.size() == 0) begin
               $error("response with no request outstanding: 0x%0h", rsp_tdata);
               mismatch_cnt++;
            end else begin
               want_line = line_q.pop_front();
               check_field("scl", want_line.scl, got_line.scl);
               check_field("sda_level", want_line.sda_level, got_line.sda_level);
               check_field("sda_drive", want_line.sda_drive, got_line.sda_drive);
               check_field("busy_res", want_line.busy, got_line.busy);
               check_field("done_res", want_line.done, got_line.done);
               check_field("rx_byte", want_line.rx_byte, got_line.rx_byte);
               check_field("ack_failed", want_line.ack_failed, got_line.ack_failed);
               checked_cnt++;
               if (want_line.done) command_cnt++;
            end
         end
         // a request taken at this edge still sees the old register values
         if (req_tvalid && req_tready)
            line_q.push_back(predict_line(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9]));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_ACK_TIMEOUT_POLLS: cfg_timeout  = csr_pwdata[7:0];
               REG_WRITE_HALF_PERIOD: cfg_wr_half  = csr_pwdata[7:0];
               REG_READ_HALF_PERIOD:  cfg_rd_half  = csr_pwdata[7:0];
               REG_START_STOP_HOLD:   cfg_ss_hold  = csr_pwdata[7:0];
               REG_ACK_POLL_INTERVAL: cfg_poll_int = csr_pwdata[7:0];
               REG_POST_ACK_HOLD:     cfg_post_ack = csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
      fail_total    <= mismatch_cnt;
      pending_total <= line_q.size();
      checked_total <= checked_cnt;
      command_total <= command_cnt;
      timeout_total <= timeout_cnt;
   end

endmodule

>>> tb/tb_i2c_master_bit_sequencer.sv
`timescale 1ns / 100ps
// top of the i2c master bit sequencer testbench: clock, reset, request and
// register stimulus, verdict; depends on i2cms_pkg, i2cms_checker and the block
module tb_i2c_master_bit_sequencer;
   import i2cms_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DONE_BIT = 4;            // done_res position in rsp_tdata
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam int PLAN_LEN = 7;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;            // [7:0] tx_byte, [8] ack_after_read, [9] sda_in
   logic [2:0]  req_tuser = '0;            // [2:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;                 // [0] scl, [1] sda_level, [2] sda_drive, [3] busy_res,
                                           // [4] done_res, [12:5] rx_byte, [13] ack_failed
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_total, pending_total, checked_total, command_total, timeout_total;

   // percentages of cycles in which each side holds off
   int idle_pct = 0;
   int stall_pct = 0;
   int cycle_cnt = 0;

   // a typical transaction; the next command is taken from here, moving on
   // whenever a command completes
   cmd_type cmd_plan[PLAN_LEN] = '{CMD_START, CMD_WRITE, CMD_WAIT_ACK, CMD_WRITE,
                                   CMD_WAIT_ACK, CMD_READ, CMD_STOP};
   int plan_pos = 0;

   i2c_master_bit_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   i2cms_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_total    (fail_total),
      .pending_total (pending_total),
      .checked_total (checked_total),
      .command_total (command_total),
      .timeout_total (timeout_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // follow the command plan and guard against a hang
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[DONE_BIT])
         plan_pos <= (plan_pos + 1) % PLAN_LEN;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one request; the sender may hold off for a random number of cycles first
   task automatic send_request(input logic [2:0] func, input logic [7:0] tx,
                               input logic ack, input logic sda);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'b0, sda, ack, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and wait until every response has been checked
   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_total != 0) @(posedge clock);
   endtask

   // setup cycle then access cycle
   task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'b0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_settings(input logic [7:0] timeout, input logic [7:0] wr_half,
                                input logic [7:0] rd_half, input logic [7:0] ss_hold,
                                input logic [7:0] poll_int, input logic [7:0] post_ack);
      write_register(REG_ACK_TIMEOUT_POLLS, timeout);
      write_register(REG_WRITE_HALF_PERIOD, wr_half);
      write_register(REG_READ_HALF_PERIOD, rd_half);
      write_register(REG_START_STOP_HOLD, ss_hold);
      write_register(REG_ACK_POLL_INTERVAL, poll_int);
      write_register(REG_POST_ACK_HOLD, post_ack);
   endtask

   // mostly ticks and planned commands, some arbitrary func codes as noise;
   // sda is high more often so that acknowledge polls can time out
   task automatic run_random(input int count);
      int pick;
      logic [2:0] func;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 50) func = CMD_IDLE;
         else if (pick < 85) func = cmd_plan[plan_pos];
         else func = 3'($urandom_range(7));
         send_request(func, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(99) < 70);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all holds zero: every command but a read completes in the tick that takes it
      load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(CMD_IDLE, 8'h00, 1'b0, 1'b0);
      send_request(FUNC_SPARE_LO, 8'hFF, 1'b1, 1'b1);
      send_request(FUNC_SPARE_HI, 8'h5A, 1'b0, 1'b0);
      send_request(CMD_START, 8'h00, 1'b0, 1'b1);
      send_request(CMD_STOP, 8'h00, 1'b0, 1'b1);
      send_request(CMD_WRITE, 8'h00, 1'b0, 1'b1);
      send_request(CMD_WRITE, 8'hFF, 1'b1, 1'b0);
      send_request(CMD_WRITE, 8'hA5, 1'b0, 1'b1);
      send_request(CMD_READ, 8'h00, 1'b1, 1'b1);
      send_request(CMD_READ, 8'hFF, 1'b0, 1'b0);
      send_request(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0);
      // zero timeout limit: the first failed poll stops
      send_request(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1);
      drain_requests();

      // widest timeout with zero poll interval: all polls inside one tick
      load_settings(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1);
      send_request(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0);
      drain_requests();

      // commands arriving while a start is held are plain ticks
      write_register(REG_START_STOP_HOLD, 8'd3);
      send_request(CMD_START, 8'h00, 1'b0, 1'b1);
      send_request(CMD_STOP, 8'h00, 1'b0, 1'b0);
      send_request(CMD_WRITE, 8'hC3, 1'b1, 1'b1);
      send_request(CMD_IDLE, 8'h00, 1'b0, 1'b1);
      send_request(CMD_IDLE, 8'h00, 1'b0, 1'b1);
      drain_requests();

      // random traffic under small settings and each idling pattern
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         load_settings(8'($urandom_range(3)), 8'($urandom_range(2)),
                       8'($urandom_range(2)), 8'($urandom_range(3)),
                       8'($urandom_range(2)), 8'($urandom_range(3)));
         run_random(120);
         drain_requests();
      end

      // every register at its maximum
      idle_pct  = 0;
      stall_pct = 0;
      load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      run_random(60);
      drain_requests();
      repeat (4) @(posedge clock);

      $display("checked %0d responses, %0d completed commands, %0d acknowledge timeouts",
               checked_total, command_total, timeout_total);
      $display("settings ran from all-zero holds through small random values to maximum");
      if (fail_total == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/i2cms_pkg.sv
hw/rtl/i2c_master_bit_sequencer.sv
tb/i2cms_checker.sv
tb/tb_i2c_master_bit_sequencer.sv
